// File: hw/rtl/bitmap_page_allocator_macros.svh
// Assertion macros for the bitmap page allocator.
// Expects clk and rst_n in the scope of each use.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// Property must hold on every clock edge out of reset.
`define BPA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true on a clock edge out of reset.
`define BPA_NEVER(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: hw/rtl/bpa_pkg.sv
// Shared types, constants and helpers of the bitmap page allocator.
// No dependencies.
package bpa_pkg;

    localparam int unsigned MAP_BYTES     = 128;
    localparam int unsigned PAGE_CAPACITY = MAP_BYTES * 8;
    localparam int unsigned ADDR_W        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int unsigned CNT_W         = $clog2(PAGE_CAPACITY + 1);
    localparam int unsigned INDEX_W       = 10;
    localparam int unsigned FUNC_W        = 2;

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(MAP_BYTES - 1);
    localparam logic [ADDR_W-1:0] SCAN_START = ADDR_W'((MAP_BYTES > 1) ? 1 : 0);
    localparam logic [CNT_W-1:0]  CAPACITY   = CNT_W'(PAGE_CAPACITY);

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [INDEX_W-1:0] page_index;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [INDEX_W-1:0] result_index;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_RESPOND
    } state_t;

    typedef struct packed {
        logic load;
        logic lookup;
        logic scan;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic req_alloc;
        logic req_lookup;
        logic full;
        logic hit;
        logic last;
        logic out_free;
    } status_t;

    function automatic logic [2:0] first_zero(input logic [7:0] b);
        logic [2:0] r;
        r = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (!b[k])
            begin
                r = 3'(k);
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/bpa_ctrl.sv
// Controller state machine of the bitmap page allocator.
// Depends on bpa_pkg.
module bpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  bpa_pkg::status_t  st,
    output bpa_pkg::cmd_t     cmd,
    output bpa_pkg::state_t   state
);

    bpa_pkg::state_t state_reg;
    bpa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpa_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (st.req_alloc && !st.full)
                    begin
                        state_next = bpa_pkg::ST_SCAN;
                    end
                    else if (st.req_lookup)
                    begin
                        state_next = bpa_pkg::ST_LOOKUP;
                    end
                    else
                    begin
                        state_next = bpa_pkg::ST_RESPOND;
                    end
                end
            end
            bpa_pkg::ST_LOOKUP:
            begin
                state_next = bpa_pkg::ST_RESPOND;
            end
            bpa_pkg::ST_SCAN:
            begin
                if (st.hit || st.last)
                begin
                    state_next = bpa_pkg::ST_RESPOND;
                end
            end
            bpa_pkg::ST_RESPOND:
            begin
                if (st.out_free)
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            bpa_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            bpa_pkg::ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            bpa_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            bpa_pkg::ST_RESPOND:
            begin
                cmd.out_load = st.out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    assign state = state_reg;

endmodule

// File: hw/rtl/bpa_datapath.sv
// Datapath of the bitmap page allocator: bitmap memory, scan address,
// allocated count and output register. Depends on bpa_pkg and the macro header.
`include "bitmap_page_allocator_macros.svh"

module bpa_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  bpa_pkg::req_t     req,
    input  bpa_pkg::cmd_t     cmd,
    input  bpa_pkg::state_t   state,
    input  logic              rsp_stall,
    output bpa_pkg::status_t  st,
    output logic              rsp_valid,
    output bpa_pkg::rsp_t     rsp
);

    logic [7:0] bitmap_mem [bpa_pkg::MAP_BYTES];
    logic [bpa_pkg::MAP_BYTES-1:0] entry_valid_reg;

    logic [bpa_pkg::FUNC_W-1:0]  func_reg;
    logic [bpa_pkg::INDEX_W-1:0] page_reg;
    logic [bpa_pkg::ADDR_W-1:0]  issue_addr_reg;
    logic [bpa_pkg::ADDR_W-1:0]  rd_addr_reg;
    logic [7:0]                  rd_byte_reg;
    logic                        rd_live_reg;
    logic [bpa_pkg::CNT_W-1:0]   count_reg;
    logic                        res_ok_reg;
    logic [bpa_pkg::INDEX_W-1:0] res_idx_reg;
    logic                        rsp_valid_reg;
    bpa_pkg::rsp_t               rsp_reg;

    logic [bpa_pkg::ADDR_W-1:0]  rd_sel;
    logic [bpa_pkg::ADDR_W-1:0]  req_byte;
    logic [7:0]                  rd_data;
    logic [2:0]                  zero_bit;
    logic [2:0]                  page_bit;
    logic                        in_range;
    logic                        bit_set;
    logic                        free_ok;
    logic                        alloc_hit;
    logic                        wr_en;
    logic [7:0]                  wr_data;

    assign req_byte  = bpa_pkg::ADDR_W'(req.page_index >> 3);
    assign rd_sel    = cmd.load
                     ? ((req.func == bpa_pkg::FUNC_ALLOC) ? '0 : req_byte)
                     : issue_addr_reg;
    assign rd_data   = rd_live_reg ? rd_byte_reg : 8'h00;
    assign zero_bit  = bpa_pkg::first_zero(rd_data);
    assign page_bit  = page_reg[2:0];
    assign in_range  = 32'(page_reg) < bpa_pkg::PAGE_CAPACITY;
    assign bit_set   = rd_data[page_bit];
    assign free_ok   = (func_reg == bpa_pkg::FUNC_FREE) && in_range && bit_set;
    assign alloc_hit = cmd.scan && st.hit;
    assign wr_en     = alloc_hit || (cmd.lookup && free_ok);
    assign wr_data   = cmd.scan ? (rd_data | (8'h01 << zero_bit))
                                : (rd_data & ~(8'h01 << page_bit));

    assign st.req_alloc  = req.func == bpa_pkg::FUNC_ALLOC;
    assign st.req_lookup = (req.func == bpa_pkg::FUNC_FREE) || (req.func == bpa_pkg::FUNC_QUERY);
    assign st.full       = count_reg >= bpa_pkg::CAPACITY;
    assign st.hit        = rd_data != 8'hFF;
    assign st.last       = rd_addr_reg == bpa_pkg::LAST_ADDR;
    assign st.out_free   = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[rd_addr_reg] <= wr_data;
        end
        rd_byte_reg <= bitmap_mem[rd_sel];
        rd_live_reg <= entry_valid_reg[rd_sel];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            entry_valid_reg[rd_addr_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg       <= req.func;
            page_reg       <= req.page_index;
            rd_addr_reg    <= rd_sel;
            issue_addr_reg <= bpa_pkg::SCAN_START;
            res_ok_reg     <= 1'b0;
            res_idx_reg    <= '0;
        end
        else if (cmd.scan)
        begin
            rd_addr_reg <= issue_addr_reg;
            if (issue_addr_reg != bpa_pkg::LAST_ADDR)
            begin
                issue_addr_reg <= issue_addr_reg + 1'b1;
            end
            if (st.hit)
            begin
                res_ok_reg  <= 1'b1;
                res_idx_reg <= bpa_pkg::INDEX_W'({rd_addr_reg, zero_bit});
            end
        end
        else if (cmd.lookup)
        begin
            res_ok_reg <= free_ok
                       || ((func_reg == bpa_pkg::FUNC_QUERY) && in_range && !bit_set);
        end
        if (cmd.out_load)
        begin
            rsp_reg.ok           <= res_ok_reg;
            rsp_reg.result_index <= res_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (alloc_hit)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.lookup && free_ok && (count_reg != '0))
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `BPA_NEVER(a_count_bound, count_reg > bpa_pkg::CAPACITY, "allocated count above capacity")
    `BPA_ASSERT(a_alloc_count, alloc_hit |=> count_reg == $past(count_reg) + 1'b1, "allocation did not bump count")
    `BPA_NEVER(a_write_state, wr_en && (state != bpa_pkg::ST_LOOKUP) && (state != bpa_pkg::ST_SCAN), "bitmap written outside lookup or scan")

endmodule

// File: hw/rtl/bitmap_page_allocator.sv
// Bitmap page allocator, first fit: allocate, free and query of page slots.
// Flow of an item: a refused allocate or an unused code goes from idle straight to respond,
// free and query pass through lookup, and an allocate scans bytes from byte 0 until one has a
// free bit or the last byte is read. One item at a time: a new item is taken only in idle, once
// the result is registered; the respond state waits while the output is stalled.
// Reset clears the allocated count and every bitmap entry at once; no clearing pass.
module bitmap_page_allocator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bpa_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bpa_pkg::rsp_t  rsp
);

    bpa_pkg::cmd_t    cmd;
    bpa_pkg::status_t st;
    bpa_pkg::state_t  state;

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .st        (st),
        .cmd       (cmd),
        .state     (state)
    );

    bpa_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .state     (state),
        .rsp_stall (rsp_stall),
        .st        (st),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

// File: dv/bitmap_page_allocator_tb.sv
// Self-checking testbench of the bitmap page allocator: a directed table, then random
// allocate/free/query traffic with idles on both sides, checked against an inline predictor.
// Depends on bpa_pkg and bitmap_page_allocator.
`timescale 1ns / 100ps

module bitmap_page_allocator_tb;

    localparam logic [bpa_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RAND_ITEMS  = 1500;
    localparam int FULL_TARGET = 30;
    localparam int IDLE_LIMIT  = 2000;
    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        bit            typed;
        bpa_pkg::req_t req;
        bpa_pkg::rsp_t rsp;
    } stim_row_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    bpa_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    bpa_pkg::rsp_t rsp;

    bit [7:0]      page_map [bpa_pkg::MAP_BYTES];
    int unsigned   pages_used;
    bpa_pkg::rsp_t expected_rsp_q [$];
    stim_row_t     directed_rows [$];
    bit            calm;
    int            hold_cnt = 0;
    int            idle_cycles = 0;
    int            errors;
    int            reqs_taken;
    int            rsps_seen;
    int            alloc_ok;
    int            free_ok;
    int            full_refusals;

    bitmap_page_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic stim_row_t stim_row(bit typed, logic [bpa_pkg::FUNC_W-1:0] f, int idx,
                                           bit ok, int ridx);
        stim_row_t s;
        s.typed            = typed;
        s.req.func         = f;
        s.req.page_index   = bpa_pkg::INDEX_W'(idx);
        s.rsp.ok           = ok;
        s.rsp.result_index = bpa_pkg::INDEX_W'(ridx);
        return s;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // first-fit allocation, free and query against the shadow page map
    function automatic bpa_pkg::rsp_t predict_alloc_rsp(bpa_pkg::req_t r);
        bpa_pkg::rsp_t o;
        int            b;
        int            k;
        int            slot;
        bit            found;
        o     = '0;
        found = 1'b0;
        slot  = int'(r.page_index);
        case (r.func)
            bpa_pkg::FUNC_ALLOC:
            begin
                if (pages_used >= bpa_pkg::PAGE_CAPACITY)
                    full_refusals++;
                else
                begin
                    for (b = 0; b < bpa_pkg::MAP_BYTES && !found; b++)
                    begin
                        for (k = 0; k < 8 && !found; k++)
                        begin
                            if (!page_map[b][k])
                            begin
                                page_map[b][k] = 1'b1;
                                o.ok           = 1'b1;
                                o.result_index = bpa_pkg::INDEX_W'(b * 8 + k);
                                pages_used++;
                                alloc_ok++;
                                found = 1'b1;
                            end
                        end
                    end
                end
            end
            bpa_pkg::FUNC_FREE:
            begin
                if (slot < bpa_pkg::PAGE_CAPACITY && page_map[slot / 8][slot % 8])
                begin
                    page_map[slot / 8][slot % 8] = 1'b0;
                    if (pages_used > 0)
                        pages_used--;
                    o.ok = 1'b1;
                    free_ok++;
                end
            end
            bpa_pkg::FUNC_QUERY:
                o.ok = (slot < bpa_pkg::PAGE_CAPACITY) && !page_map[slot / 8][slot % 8];
            default:
                o = '0;
        endcase
        return o;
    endfunction

    function automatic logic [bpa_pkg::INDEX_W-1:0] pick_used_slot();
        logic [bpa_pkg::INDEX_W-1:0] idx;
        int                          tries;
        idx = bpa_pkg::INDEX_W'($urandom_range(0, 1023));
        for (tries = 0; tries < 64 && pages_used > 0; tries++)
        begin
            if (page_map[idx / 8][idx % 8])
                return idx;
            idx = bpa_pkg::INDEX_W'($urandom_range(0, 1023));
        end
        return idx;
    endfunction

    function automatic bpa_pkg::req_t pick_req(bit filling);
        bpa_pkg::req_t r;
        int            roll;
        r.page_index = bpa_pkg::INDEX_W'($urandom_range(0, 1023));
        roll         = $urandom_range(0, 99);
        if (filling)
        begin
            if (roll < 88)
                r.func = bpa_pkg::FUNC_ALLOC;
            else if (roll < 94)
                r.func = bpa_pkg::FUNC_FREE;
            else if (roll < 98)
                r.func = bpa_pkg::FUNC_QUERY;
            else
                r.func = FUNC_UNUSED;
            if (r.func == bpa_pkg::FUNC_FREE)
                r.page_index = pick_used_slot();
        end
        else
        begin
            if (roll < 30)
                r.func = bpa_pkg::FUNC_ALLOC;
            else if (roll < 75)
                r.func = bpa_pkg::FUNC_FREE;
            else if (roll < 93)
                r.func = bpa_pkg::FUNC_QUERY;
            else
                r.func = FUNC_UNUSED;
            if ((r.func == bpa_pkg::FUNC_FREE || r.func == bpa_pkg::FUNC_QUERY)
                && roll % 5 != 0)
                r.page_index = pick_used_slot();
        end
        return r;
    endfunction

    task automatic send_req(bpa_pkg::req_t r, bit typed, bpa_pkg::rsp_t typed_rsp);
        int            gap;
        bpa_pkg::rsp_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = predict_alloc_rsp(r);
        expected_rsp_q.push_back(typed ? typed_rsp : predicted);
        reqs_taken++;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else
        begin
            rsp_stall <= !calm && ($urandom_range(0, 2) == 0);
            hold_cnt  <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        bpa_pkg::rsp_t want;
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            rsps_seen++;
            if (expected_rsp_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result ok=%0d index=%0d", $time,
                             rsp.ok, rsp.result_index);
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.ok !== want.ok)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: ok mismatch: expected %0d, actual %0d", $time,
                                 want.ok, rsp.ok);
                end
                if (rsp.result_index !== want.result_index)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result_index mismatch: expected %0d, actual %0d",
                                 $time, want.result_index, rsp.result_index);
                end
            end
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int            n;
        int            i;
        bpa_pkg::req_t r;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        calm        = 1'b0;
        pages_used  = 0;
        foreach (page_map[b])
            page_map[b] = 8'h00;

        directed_rows.push_back(stim_row(1'b1, bpa_pkg::FUNC_QUERY, 0,       1'b1, 0));
        directed_rows.push_back(stim_row(1'b1, bpa_pkg::FUNC_QUERY, 1023,    1'b1, 0));
        directed_rows.push_back(stim_row(1'b1, bpa_pkg::FUNC_FREE,  0,       1'b0, 0));
        directed_rows.push_back(stim_row(1'b1, bpa_pkg::FUNC_FREE,  1023,    1'b0, 0));
        directed_rows.push_back(stim_row(1'b1, FUNC_UNUSED,         1023,    1'b0, 0));
        directed_rows.push_back(stim_row(1'b1, FUNC_UNUSED,         0,       1'b0, 0));
        directed_rows.push_back(stim_row(1'b1, bpa_pkg::FUNC_ALLOC, 1023,    1'b1, 0));
        directed_rows.push_back(stim_row(1'b1, bpa_pkg::FUNC_ALLOC, 0,       1'b1, 1));
        directed_rows.push_back(stim_row(1'b1, bpa_pkg::FUNC_ALLOC, 0,       1'b1, 2));
        directed_rows.push_back(stim_row(1'b1, bpa_pkg::FUNC_QUERY, 1,       1'b0, 0));
        directed_rows.push_back(stim_row(1'b1, bpa_pkg::FUNC_FREE,  1,       1'b1, 0));
        directed_rows.push_back(stim_row(1'b1, bpa_pkg::FUNC_FREE,  1,       1'b0, 0));
        directed_rows.push_back(stim_row(1'b1, bpa_pkg::FUNC_ALLOC, 0,       1'b1, 1));
        for (i = 0; i < 8; i++)
            directed_rows.push_back(stim_row(1'b0, bpa_pkg::FUNC_ALLOC, 10'h3FF - i, 1'b0, 0));
        directed_rows.push_back(stim_row(1'b0, bpa_pkg::FUNC_FREE,  5,       1'b0, 0));
        directed_rows.push_back(stim_row(1'b0, bpa_pkg::FUNC_ALLOC, 10'h155, 1'b0, 0));
        directed_rows.push_back(stim_row(1'b0, bpa_pkg::FUNC_QUERY, 10'h2AA, 1'b0, 0));
        directed_rows.push_back(stim_row(1'b1, FUNC_UNUSED,         10'h155, 1'b0, 0));

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[j])
            send_req(directed_rows[j].req, directed_rows[j].typed, directed_rows[j].rsp);

        n = 0;
        while (n < RAND_ITEMS || full_refusals < FULL_TARGET)
        begin
            if (n % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            r = pick_req(full_refusals < FULL_TARGET);
            send_req(r, 1'b0, '0);
            n++;
        end
        req_valid <= 1'b0;

        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (bpa_pkg::MAP_BYTES + 8) @(posedge clk);

        $display("Covered %0d items, %0d results: %0d pages given, %0d freed,",
                 reqs_taken, rsps_seen, alloc_ok, free_ok);
        $display("and %0d allocates refused with every page in use.", full_refusals);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: bitmap_page_allocator.f
+incdir+hw/rtl
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bpa_datapath.sv
hw/rtl/bitmap_page_allocator.sv
dv/bitmap_page_allocator_tb.sv
